FILE: sv/llh_pkg.sv
// ---------------------------------------------------------------------------
// Log-linear latency histogram package
// Shared widths, register indexes and the control beat type.
// ---------------------------------------------------------------------------
package llh_pkg;

   localparam int LATENCY_W   = 32;
   localparam int DIR_W       = 2;
   localparam int MSB_W       = 5;
   localparam int RSP_INDEX_W = 11;
   localparam int COUNT_W     = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 1;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_INDEX_W = 1;

   localparam logic [REG_INDEX_W-1:0] REG_RECORD_ENABLE = 1'b0;

   typedef struct packed {
      logic valid;
      logic rec;
   } llh_ctl_type;

endpackage

FILE: sv/llh_csr.sv
// ---------------------------------------------------------------------------
// Histogram control register port
// APB-style write/read access to the record_enable register.
// ---------------------------------------------------------------------------
module llh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [llh_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [llh_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [llh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic                             record_enable
);
   import llh_pkg::*;

   logic                   record_enable_ff;
   logic                   record_enable_in;
   logic [REG_INDEX_W-1:0] reg_index;
   logic                   wr_hit;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;
   assign wr_hit    = psel & penable & pwrite & pready & (reg_index == REG_RECORD_ENABLE);

   assign record_enable_in = wr_hit ? pwdata[0] : record_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_enable_ff <= 1'b0;
      end else begin
         record_enable_ff <= record_enable_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_RECORD_ENABLE) begin
         prdata[0] = record_enable_ff;
      end
   end

   assign record_enable = record_enable_ff;

endmodule

FILE: sv/llh_mapper.sv
// ---------------------------------------------------------------------------
// Histogram bucket mapper
// Two stages: find the top set bit, then form the clamped bucket index and
// the counter memory address.
// ---------------------------------------------------------------------------
module llh_mapper #(
   parameter int MANTISSA_BITS = 6,
   parameter int BUCKET_COUNT  = 1216,
   parameter int DIRECTIONS    = 2,
   parameter int IDX_W         = $clog2(BUCKET_COUNT),
   parameter int ADDR_W        = $clog2(DIRECTIONS * BUCKET_COUNT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [llh_pkg::LATENCY_W-1:0]   in_latency,
   input  logic [llh_pkg::DIR_W-1:0]       in_direction,
   input  logic                            record_enable,
   output llh_pkg::llh_ctl_type            out_ctl,
   input  logic                            out_ready,
   output logic [IDX_W-1:0]                out_index,
   output logic [ADDR_W-1:0]               out_addr
);
   import llh_pkg::*;

   localparam int RAW_W = (MANTISSA_BITS + 6 > IDX_W) ? MANTISSA_BITS + 6 : IDX_W;
   localparam int LAST  = BUCKET_COUNT - 1;

   logic                 s1_valid_ff, s1_valid_in;
   logic [LATENCY_W-1:0] s1_lat_ff;
   logic [DIR_W-1:0]     s1_dir_ff;

   logic                 s2_valid_ff, s2_valid_in;
   logic [LATENCY_W-1:0] s2_lat_ff;
   logic [MSB_W-1:0]     s2_msb_ff, s2_msb_in;
   logic                 s2_rec_ff, s2_rec_in;
   logic [ADDR_W-1:0]    s2_base_ff, s2_base_in;

   logic                 load1, load2;
   logic                 counted;
   logic [MSB_W-1:0]     grp;
   logic [LATENCY_W-1:0] shifted;
   logic [RAW_W-1:0]     raw;
   logic [IDX_W-1:0]     idx;

   assign load2    = ~s2_valid_ff | out_ready;
   assign load1    = ~s1_valid_ff | load2;
   assign in_ready = load1;

   assign s1_valid_in = load1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = load2 ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s2_msb_in = '0;
      for (int i = 0; i < LATENCY_W; i++) begin
         if (s1_lat_ff[i]) begin
            s2_msb_in = MSB_W'(i);
         end
      end
   end

   assign counted    = ({1'b0, s1_dir_ff} < (DIR_W + 1)'(DIRECTIONS));
   assign s2_rec_in  = record_enable & counted;
   assign s2_base_in = counted ? ADDR_W'(ADDR_W'(s1_dir_ff) * ADDR_W'(BUCKET_COUNT)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_lat_ff <= in_latency;
         s1_dir_ff <= in_direction;
      end
      if (load2) begin
         s2_lat_ff  <= s1_lat_ff;
         s2_msb_ff  <= s2_msb_in;
         s2_rec_ff  <= s2_rec_in;
         s2_base_ff <= s2_base_in;
      end
   end

   assign grp     = s2_msb_ff - MSB_W'(MANTISSA_BITS);
   assign shifted = s2_lat_ff >> grp;

   always_comb begin
      if (s2_msb_ff <= MSB_W'(MANTISSA_BITS)) begin
         raw = RAW_W'(s2_lat_ff[MANTISSA_BITS:0]);
      end else begin
         raw = RAW_W'((RAW_W'(grp) + RAW_W'(1)) << MANTISSA_BITS)
             + RAW_W'(shifted[MANTISSA_BITS-1:0]);
      end
      if (raw > RAW_W'(LAST)) begin
         idx = IDX_W'(LAST);
      end else begin
         idx = IDX_W'(raw);
      end
   end

   assign out_ctl.valid = s2_valid_ff;
   assign out_ctl.rec   = s2_rec_ff;
   assign out_index     = idx;
   assign out_addr      = s2_base_ff + ADDR_W'(idx);

endmodule

FILE: sv/llh_counter.sv
// ---------------------------------------------------------------------------
// Histogram counter store
// Counter memory with read-modify-write, write forwarding, a clearing pass
// after reset and the result register.
// ---------------------------------------------------------------------------
module llh_counter #(
   parameter int BUCKET_COUNT = 1216,
   parameter int DIRECTIONS   = 2,
   parameter int IDX_W        = $clog2(BUCKET_COUNT),
   parameter int ADDR_W       = $clog2(DIRECTIONS * BUCKET_COUNT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  llh_pkg::llh_ctl_type              in_ctl,
   output logic                              in_ready,
   input  logic [IDX_W-1:0]                  in_index,
   input  logic [ADDR_W-1:0]                 in_addr,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [llh_pkg::RSP_INDEX_W-1:0]   rsp_index,
   output logic [llh_pkg::COUNT_W-1:0]       rsp_count,
   output logic                              rsp_recorded,
   output logic                              clearing
);
   import llh_pkg::*;

   localparam int DEPTH = DIRECTIONS * BUCKET_COUNT;

   logic [COUNT_W-1:0] counter_mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   logic               clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic               s3_valid_ff, s3_valid_in;
   logic               s3_rec_ff;
   logic [ADDR_W-1:0]  s3_addr_ff;
   logic [IDX_W-1:0]   s3_index_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [COUNT_W-1:0] fwd_data_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_INDEX_W-1:0] rsp_index_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic                   rsp_rec_ff;

   logic               out_en, adv3, load3, rd_en;
   logic [COUNT_W-1:0] cur, nxt;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COUNT_W-1:0] wr_data;

   assign out_en   = ~rsp_valid_ff | rsp_ready;
   assign adv3     = s3_valid_ff & out_en;
   assign load3    = ~s3_valid_ff | out_en;
   assign in_ready = load3;
   assign rd_en    = load3 & in_ctl.valid;

   assign cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign nxt = (&cur) ? cur : cur + COUNT_W'(1);

   assign fwd_hit_in = adv3 & s3_rec_ff & in_ctl.rec & (s3_addr_ff == in_addr);

   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = adv3 & s3_rec_ff;
         wr_addr = s3_addr_ff;
         wr_data = nxt;
      end
   end

   assign clr_busy_in  = clr_busy_ff & (clr_addr_ff != ADDR_W'(DEPTH - 1));
   assign clr_addr_in  = clr_busy_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   assign s3_valid_in  = load3 ? in_ctl.valid : s3_valid_ff;
   assign rsp_valid_in = out_en ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         counter_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= counter_mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_rec_ff   <= in_ctl.rec;
         s3_addr_ff  <= in_addr;
         s3_index_ff <= in_index;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= nxt;
      end
      if (out_en) begin
         rsp_index_ff <= RSP_INDEX_W'(s3_index_ff);
         rsp_count_ff <= s3_rec_ff ? nxt : '0;
         rsp_rec_ff   <= s3_rec_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_recorded = rsp_rec_ff;
   assign clearing     = clr_busy_ff;

endmodule

FILE: sv/log_linear_latency_histogram_top.sv
// ---------------------------------------------------------------------------
// Log-linear latency histogram
// Maps each latency sample to a log-linear bucket and counts it per direction.
//
// req beat: tdata holds the latency in microseconds, tuser the direction
// (read, write, other). rsp beat: tdata holds the bucket index and the bucket
// count after the update, tuser is set when the sample was counted. Counting
// is switched on by the record_enable register on the csr port.
// A request beat passes through mapper stages s1 and s2, counter stage s3 and
// the result register; one beat per cycle is sustained while rsp_tready is
// high, since a read-modify-write of the counter memory completes every
// cycle and a write to the same counter is forwarded to the next read.
// After reset, a clearing pass zeroes the counter memory one entry per cycle,
// all DIRECTIONS * BUCKET_COUNT entries (2432 with the defaults); req_tready
// stays low until it finishes. A stall on rsp_tready holds the result register;
// the pipeline keeps taking beats until its three stages are full.
module log_linear_latency_histogram_top #(
   parameter int MANTISSA_BITS = 6,
   parameter int BUCKET_COUNT  = 1216,
   parameter int DIRECTIONS    = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [llh_pkg::REQ_TDATA_W-1:0]  req_tdata,   // latency_usec
   input  logic [llh_pkg::REQ_TUSER_W-1:0]  req_tuser,   // direction
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [llh_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // bucket_index, bucket_count
   output logic [llh_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // recorded
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [llh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [llh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [llh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import llh_pkg::*;

   localparam int IDX_W  = $clog2(BUCKET_COUNT);
   localparam int ADDR_W = $clog2(DIRECTIONS * BUCKET_COUNT);

   logic                   record_enable;
   logic                   clearing;
   logic                   map_in_ready;
   llh_ctl_type            map_ctl;
   logic                   cnt_in_ready;
   logic [IDX_W-1:0]       map_index;
   logic [ADDR_W-1:0]      map_addr;
   logic [RSP_INDEX_W-1:0] rsp_index;
   logic [COUNT_W-1:0]     rsp_count;
   logic                   rsp_recorded;

   llh_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .record_enable (record_enable)
   );

   llh_mapper #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .BUCKET_COUNT  (BUCKET_COUNT),
      .DIRECTIONS    (DIRECTIONS),
      .IDX_W         (IDX_W),
      .ADDR_W        (ADDR_W)
   ) u_mapper (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid & ~clearing),
      .in_ready      (map_in_ready),
      .in_latency    (req_tdata),
      .in_direction  (req_tuser),
      .record_enable (record_enable),
      .out_ctl       (map_ctl),
      .out_ready     (cnt_in_ready),
      .out_index     (map_index),
      .out_addr      (map_addr)
   );

   llh_counter #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .DIRECTIONS   (DIRECTIONS),
      .IDX_W        (IDX_W),
      .ADDR_W       (ADDR_W)
   ) u_counter (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (map_ctl),
      .in_ready     (cnt_in_ready),
      .in_index     (map_index),
      .in_addr      (map_addr),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_count    (rsp_count),
      .rsp_recorded (rsp_recorded),
      .clearing     (clearing)
   );

   assign req_tready = map_in_ready & ~clearing;
   assign rsp_tdata  = {{(RSP_TDATA_W - COUNT_W - RSP_INDEX_W){1'b0}}, rsp_count, rsp_index};
   assign rsp_tuser  = rsp_recorded;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Log-linear latency histogram testbench
// Streams latency samples into the histogram, predicts the bucket index and
// the per-direction count of each one, and checks every result beat against
// the prediction. Random gaps and stalls on both streams; record_enable is
// toggled between phases through the csr port and read back.
// ---------------------------------------------------------------------------
module tb_top;
   import llh_pkg::*;

   localparam int MANT_BITS    = 6;
   localparam int N_BUCKETS    = 1216;
   localparam int N_DIRS       = 2;
   localparam int DIR_IDX_W    = $clog2(N_DIRS);
   localparam int DRAIN_CYCLES = 10;
   localparam int N_HOT        = 8;
   localparam int HOT_W        = $clog2(N_HOT);

   localparam logic [DIR_W-1:0] DIR_READ  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_WRITE = 2'd1;
   localparam logic [DIR_W-1:0] DIR_OTHER = 2'd2;
   localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RECORD_ENABLE = CSR_ADDR_W'(REG_RECORD_ENABLE) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED      = 3'd4;

   typedef struct packed {
      logic [LATENCY_W-1:0] latency;
      logic [DIR_W-1:0]     dir;
   } sample_type;

   typedef struct packed {
      logic [RSP_INDEX_W-1:0] index;
      logic [COUNT_W-1:0]     count;
      logic                   recorded;
   } bucket_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   sample_type          pending_q[$];
   bucket_report_type   bucket_reports_q[$];
   logic [COUNT_W-1:0]  model_counts[N_DIRS][N_BUCKETS];
   logic                model_record = 1'b0;
   logic [LATENCY_W-1:0] hot_latency[N_HOT];
   int                  errors = 0;

   int         req_gap = 0;
   int         rsp_wait = 0;
   logic       req_burst = 1'b0;
   logic       rsp_burst = 1'b0;
   sample_type req_next;

   log_linear_latency_histogram_top #(
      .MANTISSA_BITS(MANT_BITS),
      .BUCKET_COUNT (N_BUCKETS),
      .DIRECTIONS   (N_DIRS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // latency_usec
      .req_tuser  (req_tuser),   // direction
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // bucket_index, bucket_count
      .rsp_tuser  (rsp_tuser),   // recorded
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [RSP_INDEX_W-1:0] bucket_for(input logic [LATENCY_W-1:0] lat);
      int msb;
      int g;
      logic [31:0] idx;
      msb = 0;
      for (int i = 0; i < LATENCY_W; i++)
         if (lat[i]) msb = i;
      if (msb <= MANT_BITS) begin
         idx = lat;
      end else begin
         g   = msb - MANT_BITS;
         idx = ((g + 1) << MANT_BITS) + ((lat >> g) & ((1 << MANT_BITS) - 1));
      end
      if (idx > N_BUCKETS - 1) idx = N_BUCKETS - 1;
      return idx[RSP_INDEX_W-1:0];
   endfunction

   function void tally_sample(input logic [LATENCY_W-1:0] lat, input logic [DIR_W-1:0] dir);
      bucket_report_type    r;
      logic [DIR_IDX_W-1:0] d;
      r.index    = bucket_for(lat);
      r.count    = '0;
      r.recorded = 1'b0;
      d          = dir[DIR_IDX_W-1:0];
      if (model_record && dir < N_DIRS) begin
         if (model_counts[d][r.index] != 32'hFFFF_FFFF)
            model_counts[d][r.index] = model_counts[d][r.index] + 1;
         r.count    = model_counts[d][r.index];
         r.recorded = 1'b1;
      end
      bucket_reports_q.push_back(r);
   endfunction

   function automatic int draw_wait(inout logic burst);
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int pick;
      int shift;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         s.latency = hot_latency[HOT_W'($urandom_range(0, N_HOT - 1))];
      end else if (pick < 85) begin
         shift     = $urandom_range(0, 31);
         s.latency = ($urandom | 32'h8000_0000) >> (31 - shift);
      end else begin
         s.latency = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      s.dir = DIR_READ;
      else if (pick < 80) s.dir = DIR_WRITE;
      else if (pick < 92) s.dir = DIR_OTHER;
      else                s.dir = DIR_SPARE;
      return s;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) tally_sample(req_tdata, req_tuser);
         if (req_gap != 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            req_next   = pending_q.pop_front();
            req_tdata  <= req_next.latency;
            req_tuser  <= req_next.dir;
            req_tvalid <= 1'b1;
            req_gap    <= draw_wait(req_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch_rsp
      bucket_report_type want;
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (bucket_reports_q.size() == 0) begin
            $display("%0t: result beat expected none actual tdata %h tuser %h", $time,
                     rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = bucket_reports_q.pop_front();
            if (rsp_tdata[RSP_INDEX_W-1:0] !== want.index) begin
               $display("%0t: bucket_index expected %0d actual %0d", $time, want.index,
                        rsp_tdata[RSP_INDEX_W-1:0]);
               errors++;
            end
            if (rsp_tdata[RSP_INDEX_W +: COUNT_W] !== want.count) begin
               $display("%0t: bucket_count expected %0d actual %0d", $time, want.count,
                        rsp_tdata[RSP_INDEX_W +: COUNT_W]);
               errors++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:RSP_INDEX_W+COUNT_W] !== '0) begin
               $display("%0t: tdata padding expected 0 actual %h", $time,
                        rsp_tdata[RSP_TDATA_W-1:RSP_INDEX_W+COUNT_W]);
               errors++;
            end
            if (rsp_tuser[0] !== want.recorded) begin
               $display("%0t: recorded expected %0d actual %0d", $time, want.recorded,
                        rsp_tuser[0]);
               errors++;
            end
         end
         w = draw_wait(rsp_burst);
         rsp_wait   <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_RECORD_ENABLE) model_record = data[0];
   endtask

   task automatic csr_check_record(input logic want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_RECORD_ENABLE;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== want) begin
         $display("%0t: record_enable readback expected %0d actual %0d", $time, want,
                  csr_prdata[0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic push_sample(input logic [LATENCY_W-1:0] lat, input logic [DIR_W-1:0] dir);
      sample_type s;
      s.latency = lat;
      s.dir     = dir;
      pending_q.push_back(s);
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++) pending_q.push_back(random_sample());
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_tvalid || bucket_reports_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      for (int d = 0; d < N_DIRS; d++)
         for (int b = 0; b < N_BUCKETS; b++) model_counts[d][b] = '0;
      for (int i = 0; i < N_HOT; i++)
         hot_latency[i] = ($urandom | 32'h8000_0000) >> (31 - $urandom_range(0, 26));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // recording off after reset: nothing counted
      csr_check_record(1'b0);
      push_sample(32'd3, DIR_READ);
      push_sample(32'd200, DIR_WRITE);
      push_sample(32'hFFFF_FFFF, DIR_READ);
      push_sample(32'd3, DIR_OTHER);
      wait_drained();

      csr_write(ADDR_RECORD_ENABLE, 32'd1);
      csr_check_record(1'b1);
      push_sample(32'd0, DIR_READ);
      push_sample(32'd1, DIR_WRITE);
      push_sample(32'd127, DIR_READ);
      push_sample(32'd128, DIR_READ);
      push_sample(32'd129, DIR_WRITE);
      push_sample(32'd255, DIR_READ);
      push_sample(32'd256, DIR_WRITE);
      push_sample(32'h0080_0000, DIR_READ);
      push_sample(32'h00FF_FFFF, DIR_READ);
      push_sample(32'h0100_0000, DIR_WRITE);
      push_sample(32'h8000_0000, DIR_READ);
      push_sample(32'hFFFF_FFFF, DIR_READ);
      push_sample(32'h5555_5555, DIR_WRITE);
      push_sample(32'hAAAA_AAAA, DIR_READ);
      // repeated hits on bucket 5: read and write counters, plus uncounted directions
      push_sample(32'd5, DIR_READ);
      push_sample(32'd5, DIR_READ);
      push_sample(32'd5, DIR_READ);
      push_sample(32'd5, DIR_WRITE);
      push_sample(32'd5, DIR_WRITE);
      push_sample(32'd5, DIR_OTHER);
      push_sample(32'd5, DIR_SPARE);
      push_sample(32'd5, DIR_READ);
      wait_drained();

      // write to an unmapped index: must leave record_enable alone
      csr_write(ADDR_UNMAPPED, 32'd0);
      csr_check_record(1'b1);
      push_random(300);
      wait_drained();

      csr_write(ADDR_RECORD_ENABLE, 32'd0);
      csr_check_record(1'b0);
      push_random(150);
      wait_drained();

      csr_write(ADDR_RECORD_ENABLE, 32'hFFFF_FFFF);
      csr_check_record(1'b1);
      push_random(400);
      wait_drained();

      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
